[rtl/rxfc_pkg.sv]
// ----------------------------------------------------------------------------
// rxfc_pkg
// Shared types, constants and helpers for the receive FIFO with CTS
// hysteresis.
// ----------------------------------------------------------------------------
package rxfc_pkg;

    // Ring geometry
    localparam int DEPTH = 64;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int BYTE_W = 8;
    localparam int THR_W = 7;
    localparam int CNT_W = ((PTR_W + 1) > THR_W) ? (PTR_W + 1) : THR_W;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(8);

    // Stream payload widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Commands carried in s_axis_tuser
    typedef enum logic {
        CMD_RECEIVE = 1'b0,
        CMD_READ    = 1'b1
    } cmd_t;

    // Result error codes
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_LINE     = 2'd1,
        ERR_OVERFLOW = 2'd2
    } err_t;

    // Control states
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_RDATA = 1'b1
    } state_t;

    // Next ring position with wrap at DEPTH
    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] pos);
        logic [PTR_W-1:0] nxt;
        if (pos == PTR_W'(DEPTH - 1))
            nxt = '0;
        else
            nxt = pos + PTR_W'(1);
        return nxt;
    endfunction

    // Free slots: (rd - wr) mod DEPTH, where zero counts as DEPTH
    function automatic logic [CNT_W-1:0] free_slots(input logic [PTR_W-1:0] rd,
                                                   input logic [PTR_W-1:0] wr);
        logic [PTR_W:0] f;
        if (rd >= wr)
            f = {1'b0, rd} - {1'b0, wr};
        else
            f = {1'b0, rd} + (PTR_W+1)'(DEPTH) - {1'b0, wr};
        if (f == '0)
            f = (PTR_W+1)'(DEPTH);
        return CNT_W'(f);
    endfunction

endpackage

[rtl/rxfc_ram.sv]
// ----------------------------------------------------------------------------
// rxfc_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module rxfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/rx_fifo_with_cts_hysteresis_unit.sv]
// ----------------------------------------------------------------------------
// rx_fifo_with_cts_hysteresis_unit
// Results are registered. A read that returns a byte passes through ST_RDATA
// for the registered RAM read and holds off the next command meanwhile.
// Throughput: one transaction per cycle while the result stream does not stall.
// Reset (rst_n low, async): ring empty, CTS asserted, not suspended,
// threshold 8. Byte storage is not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rx_fifo_with_cts_hysteresis_unit
    import rxfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration: congestion_threshold
    input  logic                 cfg_we,
    input  logic [THR_W-1:0]     cfg_wdata,
    // Command stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [7:0] rx_byte, [8] line_error
    input  logic                 s_axis_tuser,  // [0] command
    // Result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] read_valid, [8:1] read_byte, [10:9] error_code, [11] clear_to_send,
    // [12] data_available, [13] receive_suspended
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    // State registers
    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  wr_pos_reg, wr_pos_next;
    logic [PTR_W-1:0]  rd_pos_reg, rd_pos_next;
    logic              cts_reg, cts_next;
    logic              susp_reg, susp_next;
    logic [THR_W-1:0]  thr_reg;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic              rvalid_reg, rvalid_next;
    logic [BYTE_W-1:0] rbyte_reg, rbyte_next;
    err_t              err_reg, err_next;
    logic              cts_out_reg, cts_out_next;
    logic              avail_reg, avail_next;
    logic              susp_out_reg, susp_out_next;

    // Decoded input and helpers
    logic              accept;
    cmd_t              cmd;
    logic [BYTE_W-1:0] rx_byte;
    logic              line_error;
    logic [PTR_W-1:0]  wr_adv;
    logic [PTR_W-1:0]  rd_adv;
    logic              ring_full;
    logic              ring_empty;
    logic [CNT_W-1:0]  free_after_store;
    logic [CNT_W-1:0]  free_after_read;
    logic [CNT_W-1:0]  thr_ext;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_rdata;

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign cmd        = cmd_t'(s_axis_tuser);
    assign rx_byte    = s_axis_tdata[BYTE_W-1:0];
    assign line_error = s_axis_tdata[BYTE_W];

    assign wr_adv           = ptr_advance(wr_pos_reg);
    assign rd_adv           = ptr_advance(rd_pos_reg);
    assign ring_full        = (wr_adv == rd_pos_reg);
    assign ring_empty       = (rd_pos_reg == wr_pos_reg);
    assign free_after_store = free_slots(rd_pos_reg, wr_adv);
    assign free_after_read  = free_slots(rd_adv, wr_pos_reg);
    assign thr_ext          = CNT_W'(thr_reg);

    assign s_axis_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_axis_tready);

    // Byte storage; read address always follows the read position
    rxfc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_pos_reg),
        .wdata (rx_byte),
        .raddr (rd_pos_reg),
        .rdata (ram_rdata)
    );

    // Next state and result formation
    always_comb
    begin
        state_next    = state_reg;
        wr_pos_next   = wr_pos_reg;
        rd_pos_next   = rd_pos_reg;
        cts_next      = cts_reg;
        susp_next     = susp_reg;
        m_valid_next  = m_valid_reg;
        rvalid_next   = rvalid_reg;
        rbyte_next    = rbyte_reg;
        err_next      = err_reg;
        cts_out_next  = cts_out_reg;
        avail_next    = avail_reg;
        susp_out_next = susp_out_reg;
        ram_we        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                // Drain the result once taken
                if (m_valid_reg && m_axis_tready)
                begin
                    m_valid_next = 1'b0;
                end
                if (accept)
                begin
                    rvalid_next  = 1'b0;
                    rbyte_next   = '0;
                    err_next     = ERR_NONE;
                    m_valid_next = 1'b1;
                    if (cmd == CMD_RECEIVE)
                    begin
                        if (susp_reg)
                        begin
                            err_next = ERR_OVERFLOW;
                        end
                        else if (line_error)
                        begin
                            err_next = ERR_LINE;
                        end
                        else if (ring_full)
                        begin
                            susp_next = 1'b1;
                            err_next  = ERR_OVERFLOW;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            wr_pos_next = wr_adv;
                            if (cts_reg && (free_after_store < thr_ext))
                            begin
                                cts_next = 1'b0;
                            end
                        end
                    end
                    else if (!ring_empty)
                    begin
                        // Read hit: byte arrives from RAM next cycle
                        rvalid_next  = 1'b1;
                        rd_pos_next  = rd_adv;
                        susp_next    = 1'b0;
                        m_valid_next = 1'b0;
                        state_next   = ST_RDATA;
                        if (!cts_reg && (free_after_read >= thr_ext))
                        begin
                            cts_next = 1'b1;
                        end
                    end
                    cts_out_next  = cts_next;
                    susp_out_next = susp_next;
                    avail_next    = (rd_pos_next != wr_pos_next);
                end
            end
            ST_RDATA:
            begin
                rbyte_next   = ram_rdata;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wr_pos_reg  <= '0;
            rd_pos_reg  <= '0;
            cts_reg     <= 1'b1;
            susp_reg    <= 1'b0;
            thr_reg     <= THR_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wr_pos_reg  <= wr_pos_next;
            rd_pos_reg  <= rd_pos_next;
            cts_reg     <= cts_next;
            susp_reg    <= susp_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        rvalid_reg   <= rvalid_next;
        rbyte_reg    <= rbyte_next;
        err_reg      <= err_next;
        cts_out_reg  <= cts_out_next;
        avail_reg    <= avail_next;
        susp_out_reg <= susp_out_next;
    end

    // Result stream
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, susp_out_reg, avail_reg, cts_out_reg, err_reg,
                            rbyte_reg, rvalid_reg};

endmodule

[sim/tb_rx_fifo_with_cts_hysteresis_unit.sv]
// ----------------------------------------------------------------------------
// tb_rx_fifo_with_cts_hysteresis_unit
// Self-checking bench for the UART receive ring with CTS flow control.
// A short table of directed transactions (empty reads, line errors, byte
// extremes, threshold zero / 64 / above the ring size) runs first, then
// random fill/drain bursts that push the ring to full, overflow and
// suspension. A shadow ring predicts every result; results are compared
// field by field in order. Source and sink back-pressure vary per phase.
// ----------------------------------------------------------------------------
module tb_rx_fifo_with_cts_hysteresis_unit
    import rxfc_pkg::*;
();

    // Result fields, laid out as on m_axis_tdata[13:0]
    typedef struct packed {
        logic              suspended;
        logic              data_avail;
        logic              cts;
        err_t              err;
        logic [BYTE_W-1:0] read_byte;
        logic              read_valid;
    } rx_result_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PRED,
        ROW_TYPED
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [THR_W-1:0]  thr;
        cmd_t              cmd;
        logic [BYTE_W-1:0] data;
        logic              lerr;
        rx_result_t        outcome;
    } dir_row_t;

    // DUT ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [THR_W-1:0]     cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Back-pressure knobs, percent of idle cycles
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int mismatches = 0;

    // Shadow copy of the ring and flow-control state
    logic [BYTE_W-1:0] shadow_ring [DEPTH];
    logic [PTR_W-1:0]  shadow_wr = '0;
    logic [PTR_W-1:0]  shadow_rd = '0;
    logic              shadow_cts = 1'b1;
    logic              shadow_susp = 1'b0;
    logic [THR_W-1:0]  shadow_thr = THR_RESET;

    rx_result_t pending_results [$];
    dir_row_t   dir_tab [$];

    rx_fifo_with_cts_hysteresis_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20-unit clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Ring position after one step, wrapping at the ring size
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return PTR_W'((int'(p) + 1) % DEPTH);
    endfunction

    // Free slots; an empty ring counts as the full ring size
    function automatic int free_count();
        int f;
        f = (int'(shadow_rd) - int'(shadow_wr) + DEPTH) % DEPTH;
        if (f == 0)
            f = DEPTH;
        return f;
    endfunction

    // Advance the shadow ring by one command and return the result it yields
    function automatic rx_result_t predict_rx_result(input cmd_t cmd,
                                                     input logic [BYTE_W-1:0] data,
                                                     input logic lerr);
        rx_result_t r;
        logic [PTR_W-1:0] nxt;
        r = '0;
        r.err = ERR_NONE;
        if (cmd == CMD_RECEIVE)
        begin
            if (shadow_susp)
                r.err = ERR_OVERFLOW;
            else if (lerr)
                r.err = ERR_LINE;
            else
            begin
                nxt = ring_next(shadow_wr);
                if (nxt == shadow_rd)
                begin
                    shadow_susp = 1'b1;
                    r.err = ERR_OVERFLOW;
                end
                else
                begin
                    shadow_ring[shadow_wr] = data;
                    shadow_wr = nxt;
                    if (shadow_cts && free_count() < int'(shadow_thr))
                        shadow_cts = 1'b0;
                end
            end
        end
        else if (shadow_rd != shadow_wr)
        begin
            r.read_valid = 1'b1;
            r.read_byte = shadow_ring[shadow_rd];
            shadow_rd = ring_next(shadow_rd);
            if (!shadow_cts && free_count() >= int'(shadow_thr))
                shadow_cts = 1'b1;
            shadow_susp = 1'b0;
        end
        r.cts = shadow_cts;
        r.data_avail = (shadow_rd != shadow_wr);
        r.suspended = shadow_susp;
        return r;
    endfunction

    function automatic rx_result_t outcome(input bit rv, input logic [BYTE_W-1:0] rb,
                                           input err_t e, input bit cts, input bit da,
                                           input bit su);
        rx_result_t r;
        r.read_valid = rv;
        r.read_byte = rb;
        r.err = e;
        r.cts = cts;
        r.data_avail = da;
        r.suspended = su;
        return r;
    endfunction

    function automatic dir_row_t drow(input row_kind_t kind, input int thr, input cmd_t cmd,
                                      input logic [BYTE_W-1:0] data, input logic lerr,
                                      input rx_result_t exp_res);
        dir_row_t r;
        r.kind = kind;
        r.thr = THR_W'(thr);
        r.cmd = cmd;
        r.data = data;
        r.lerr = lerr;
        r.outcome = exp_res;
        return r;
    endfunction

    // Drive one command transaction; called and returns at a falling edge
    task automatic send_item(input cmd_t cmd, input logic [BYTE_W-1:0] data,
                             input logic lerr, input bit typed, input rx_result_t typed_exp);
        rx_result_t predicted;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(S_TDATA_W-BYTE_W-1){1'b0}}, lerr, data};
        s_axis_tuser <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = predict_rx_result(cmd, data, lerr);
        pending_results.push_back(typed ? typed_exp : predicted);
        @(negedge clk);
    endtask

    // Stop sending and wait until every result is back
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] thr);
        cfg_we <= 1'b1;
        cfg_wdata <= thr;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_thr = thr;
    endtask

    // Random fill / drain / mixed bursts with random content
    task automatic run_random(input int n);
        int sent;
        int seg_len;
        int mode;
        int p_read;
        cmd_t cmd;
        sent = 0;
        while (sent < n)
        begin
            mode = $urandom_range(0, 9);
            seg_len = $urandom_range(8, 90);
            p_read = (mode < 5) ? 5 : (mode < 8) ? 95 : 50;
            repeat (seg_len)
            begin
                if (sent < n)
                begin
                    cmd = ($urandom_range(0, 99) < p_read) ? CMD_READ : CMD_RECEIVE;
                    send_item(cmd, BYTE_W'($urandom_range(0, 255)),
                              ($urandom_range(0, 15) == 0), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Sink back-pressure
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);

    // Result checker
    always @(posedge clk)
    begin : result_monitor
        rx_result_t got;
        rx_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = rx_result_t'(m_axis_tdata[13:0]);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("read_valid", want.read_valid, got.read_valid);
                check_field("read_byte", want.read_byte, got.read_byte);
                check_field("error_code", want.err, got.err);
                check_field("clear_to_send", want.cts, got.cts);
                check_field("data_available", want.data_avail, got.data_avail);
                check_field("receive_suspended", want.suspended, got.suspended);
            end
        end
    end

    // Stimulus
    initial
    begin
        // empty read, byte extremes, line error, reads back in order
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_READ, 8'h00, 1'b0,
                               outcome(0, 8'h00, ERR_NONE, 1, 0, 0)));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_RECEIVE, 8'h00, 1'b0,
                               outcome(0, 8'h00, ERR_NONE, 1, 1, 0)));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_RECEIVE, 8'hFF, 1'b0,
                               outcome(0, 8'h00, ERR_NONE, 1, 1, 0)));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_RECEIVE, 8'hA5, 1'b1,
                               outcome(0, 8'h00, ERR_LINE, 1, 1, 0)));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_READ, 8'h00, 1'b0,
                               outcome(1, 8'h00, ERR_NONE, 1, 1, 0)));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_READ, 8'h00, 1'b0,
                               outcome(1, 8'hFF, ERR_NONE, 1, 0, 0)));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_READ, 8'h00, 1'b0,
                               outcome(0, 8'h00, ERR_NONE, 1, 0, 0)));
        // threshold above ring size: CTS drops on any store, never recovers
        dir_tab.push_back(drow(ROW_CFG, 127, CMD_READ, 8'h00, 1'b0, '0));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_RECEIVE, 8'h5A, 1'b0,
                               outcome(0, 8'h00, ERR_NONE, 0, 1, 0)));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_READ, 8'h00, 1'b0,
                               outcome(1, 8'h5A, ERR_NONE, 0, 0, 0)));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_READ, 8'h00, 1'b0,
                               outcome(0, 8'h00, ERR_NONE, 0, 0, 0)));
        // threshold zero: CTS never drops, any read raises it
        dir_tab.push_back(drow(ROW_CFG, 0, CMD_READ, 8'h00, 1'b0, '0));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_RECEIVE, 8'h01, 1'b0,
                               outcome(0, 8'h00, ERR_NONE, 0, 1, 0)));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_READ, 8'h00, 1'b0,
                               outcome(1, 8'h01, ERR_NONE, 1, 0, 0)));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_RECEIVE, 8'h80, 1'b0,
                               outcome(0, 8'h00, ERR_NONE, 1, 1, 0)));
        // threshold equal to ring size: hysteresis at the boundary
        dir_tab.push_back(drow(ROW_CFG, 64, CMD_READ, 8'h00, 1'b0, '0));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_RECEIVE, 8'h7F, 1'b0,
                               outcome(0, 8'h00, ERR_NONE, 0, 1, 0)));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_READ, 8'h00, 1'b0,
                               outcome(1, 8'h80, ERR_NONE, 0, 1, 0)));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_READ, 8'h00, 1'b0,
                               outcome(1, 8'h7F, ERR_NONE, 1, 0, 0)));
        // threshold one
        dir_tab.push_back(drow(ROW_CFG, 1, CMD_READ, 8'h00, 1'b0, '0));
        dir_tab.push_back(drow(ROW_TYPED, 0, CMD_RECEIVE, 8'h55, 1'b1,
                               outcome(0, 8'h00, ERR_LINE, 1, 0, 0)));
        dir_tab.push_back(drow(ROW_PRED, 0, CMD_RECEIVE, 8'hAA, 1'b0, '0));
        dir_tab.push_back(drow(ROW_PRED, 0, CMD_READ, 8'h00, 1'b1, '0));
        dir_tab.push_back(drow(ROW_PRED, 0, CMD_RECEIVE, 8'h33, 1'b0, '0));
        dir_tab.push_back(drow(ROW_PRED, 0, CMD_READ, 8'h00, 1'b0, '0));

        // reset
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        snd_idle_pct = 8;
        rcv_idle_pct = 63;
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                finish_phase();
                write_threshold(dir_tab[i].thr);
            end
            else
                send_item(dir_tab[i].cmd, dir_tab[i].data, dir_tab[i].lerr,
                          dir_tab[i].kind == ROW_TYPED, dir_tab[i].outcome);
        end

        // random phases: slow sink, then slow source, then full rate
        finish_phase();
        write_threshold(THR_W'($urandom_range(1, 64)));
        run_random(200);

        finish_phase();
        snd_idle_pct = 63;
        rcv_idle_pct = 8;
        write_threshold(THR_W'($urandom_range(0, 127)));
        run_random(200);

        finish_phase();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_threshold(THR_W'($urandom_range(1, 64)));
        run_random(200);

        finish_phase();
        if (mismatches == 0)
            $display("tb_rx_fifo_with_cts_hysteresis_unit: PASS");
        else
            $display("tb_rx_fifo_with_cts_hysteresis_unit: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("tb_rx_fifo_with_cts_hysteresis_unit: FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/rxfc_pkg.sv
rtl/rxfc_ram.sv
rtl/rx_fifo_with_cts_hysteresis_unit.sv
sim/tb_rx_fifo_with_cts_hysteresis_unit.sv
